// ===== rtl/core/pdtc_pkg.sv =====
// Package: shared types, constants and lookup functions of the text codec.
`timescale 1ns / 1ps

package pdtc_pkg;

  // Longest result run of one item
  localparam int MaxRun = 6;
  localparam int CountW = 3;

  // Queue between front and back end
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = 1;
  localparam int QueueCntW  = 2;

  // Configuration port
  localparam int PaddrW = 3;
  localparam int PdataW = 32;
  localparam logic [PaddrW-3:0] RegDirection = '0;

  // Character codes
  localparam logic [7:0] CharNul      = 8'd0;
  localparam logic [7:0] CharNewline  = 8'd10;
  localparam logic [7:0] CharUpperA   = 8'd65;
  localparam logic [7:0] CharAfterZ   = 8'd91;
  localparam logic [7:0] CharBacktick = 8'd96;
  localparam logic [7:0] CharLowerZ   = 8'd122;
  localparam logic [7:0] CharBraceL   = 8'd123;
  localparam logic [7:0] CharDel      = 8'd127;
  localparam logic [7:0] CaseOffset   = 8'd32;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_t;

  // One run of results; bytes[count-1] goes out first, bytes[0] last
  typedef struct packed {
    logic [MaxRun-1:0][7:0] bytes;
    logic [CountW-1:0]      count;
    logic                   bad;
  } run_t;

  // Front end to queue
  typedef struct packed {
    logic push;
    run_t run;
  } push_t;

  // Queue head to back end
  typedef struct packed {
    logic valid;
    run_t run;
  } head_t;

  function automatic logic [7:0] upcase(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b > CharBacktick && b <= CharLowerZ) r = b - CaseOffset;
    return r;
  endfunction

  function automatic logic holdable(input logic [7:0] u);
    return (u == "L") || (u == "P") || (u == "Q") || (u == "X") || (u == "Y") || (u == "Z");
  endfunction

  // Spelled-out word of a symbol; count of zero when the byte has none
  function automatic run_t word_of(input logic [7:0] b);
    run_t r;
    r = '0;
    case (b)
      "\\":   begin r.bytes = 48'("LQ");     r.count = 3'd2; end
      ")":    begin r.bytes = 48'("QX");     r.count = 3'd2; end
      ":":    begin r.bytes = 48'("QZ");     r.count = 3'd2; end
      ",":    begin r.bytes = 48'("YY");     r.count = 3'd2; end
      "-":    begin r.bytes = 48'("YZ");     r.count = 3'd2; end
      "\"":   begin r.bytes = 48'("XZ");     r.count = 3'd2; end
      "!":    begin r.bytes = 48'("ZY");     r.count = 3'd2; end
      "(":    begin r.bytes = 48'("XQ");     r.count = 3'd2; end
      "%":    begin r.bytes = 48'("PQ");     r.count = 3'd2; end
      ".":    begin r.bytes = 48'("ZZ");     r.count = 3'd2; end
      "#":    begin r.bytes = 48'("QP");     r.count = 3'd2; end
      ";":    begin r.bytes = 48'("ZQ");     r.count = 3'd2; end
      "'":    begin r.bytes = 48'("ZX");     r.count = 3'd2; end
      "/":    begin r.bytes = 48'("QL");     r.count = 3'd2; end
      " ":    begin r.bytes = 48'("XX");     r.count = 3'd2; end
      "?":    begin r.bytes = 48'("QQ");     r.count = 3'd2; end
      "1":    begin r.bytes = 48'("ONE");    r.count = 3'd3; end
      "2":    begin r.bytes = 48'("TWO");    r.count = 3'd3; end
      "3":    begin r.bytes = 48'("THREE");  r.count = 3'd5; end
      "4":    begin r.bytes = 48'("FOUR");   r.count = 3'd4; end
      "5":    begin r.bytes = 48'("FIVE");   r.count = 3'd4; end
      "6":    begin r.bytes = 48'("SIX");    r.count = 3'd3; end
      "7":    begin r.bytes = 48'("SEVEN");  r.count = 3'd5; end
      "8":    begin r.bytes = 48'("EIGT");   r.count = 3'd4; end
      "9":    begin r.bytes = 48'("NINE");   r.count = 3'd4; end
      "0":    begin r.bytes = 48'("ZERO");   r.count = 3'd4; end
      "&":    begin r.bytes = 48'("AND");    r.count = 3'd3; end
      "@":    begin r.bytes = 48'("AT");     r.count = 3'd2; end
      "=":    begin r.bytes = 48'("EQUALS"); r.count = 3'd6; end
      "+":    begin r.bytes = 48'("PLUS");   r.count = 3'd4; end
      "*":    begin r.bytes = 48'("STAR");   r.count = 3'd4; end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Symbol for a held letter and the raw next byte, zero when no pair
  function automatic logic [7:0] pair_symbol(input logic [7:0] first, input logic [7:0] second);
    logic [7:0] s;
    s = 8'd0;
    case (first)
      "L": if (second == "Q") s = "\\";
      "P": if (second == "Q") s = "%";
      "Q": begin
        case (second)
          "L":     s = "/";
          "P":     s = "#";
          "Q":     s = "?";
          "X":     s = ")";
          "Z":     s = ":";
          default: s = 8'd0;
        endcase
      end
      "X": begin
        case (second)
          "Q":     s = "(";
          "X":     s = " ";
          "Z":     s = "\"";
          default: s = 8'd0;
        endcase
      end
      "Y": begin
        case (second)
          "Y":     s = ",";
          "Z":     s = "-";
          default: s = 8'd0;
        endcase
      end
      "Z": begin
        case (second)
          "Q":     s = ";";
          "X":     s = "'";
          "Y":     s = "!";
          "Z":     s = ".";
          default: s = 8'd0;
        endcase
      end
      default: s = 8'd0;
    endcase
    return s;
  endfunction

  // Encode one byte into its run; bad set for a byte with no mapping
  function automatic run_t encode_run(input logic [7:0] b);
    run_t r;
    run_t w;
    r = '0;
    w = word_of(b);
    if (b > CharBacktick && b <= CharLowerZ) begin
      r.bytes = {40'd0, b - CaseOffset};
      r.count = 3'd1;
    end else if (b >= CharUpperA && b < CharAfterZ) begin
      r.bytes = {40'd0, b};
      r.count = 3'd1;
    end else if (b == CharNul) begin
      r.count = 3'd0;
    end else if (b == CharNewline) begin
      r.bytes = {40'd0, b};
      r.count = 3'd1;
    end else if (b >= CharBraceL && b <= CharDel) begin
      r.count = 3'd0;
    end else if (w.count != 3'd0) begin
      r = w;
    end else begin
      r.bytes = {40'd0, b};
      r.count = 3'd1;
      r.bad   = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/pdtc_front.sv =====
// Front end: accepts input items, keeps codec state and builds result runs.
`timescale 1ns / 1ps

module pdtc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_byte,
  input  logic            end_of_text,
  input  pdtc_pkg::dir_t  direction,
  input  logic            cfg_clear,
  input  logic            q_full,
  output pdtc_pkg::push_t push
);
  import pdtc_pkg::*;

  logic       held_valid;
  logic [7:0] held_letter;
  logic       error_latched;
  logic       held_valid_next;
  logic [7:0] held_letter_next;
  logic       error_latched_next;
  logic       accept;
  logic [7:0] u;
  logic [7:0] sym;
  run_t       r;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Classify the item and work out its run and the next state
  always_comb begin
    r                  = '0;
    held_valid_next    = held_valid;
    held_letter_next   = held_letter;
    error_latched_next = error_latched;
    u                  = upcase(in_byte);
    sym                = pair_symbol(held_letter, in_byte);
    if (error_latched) begin
      r.bytes = {40'd0, in_byte};
      r.count = 3'd1;
      r.bad   = 1'b1;
    end else if (direction == DIR_ENCODE) begin
      r = encode_run(in_byte);
      if (r.bad) error_latched_next = 1'b1;
    end else if (in_byte == CharNul) begin
      // flush the held letter, the byte itself gives nothing
      if (held_valid) begin
        r.bytes = {40'd0, held_letter};
        r.count = 3'd1;
      end
      held_valid_next  = 1'b0;
      held_letter_next = '0;
    end else if (held_valid && sym != 8'd0) begin
      r.bytes          = {40'd0, sym};
      r.count          = 3'd1;
      held_valid_next  = 1'b0;
      held_letter_next = '0;
    end else begin
      if (held_valid) begin
        r.bytes          = {40'd0, held_letter};
        r.count          = 3'd1;
        held_valid_next  = 1'b0;
        held_letter_next = '0;
      end
      // hold a pair opener unless the text ends here
      if (holdable(u) && !end_of_text) begin
        held_valid_next  = 1'b1;
        held_letter_next = u;
      end else begin
        r.bytes = {r.bytes[MaxRun-2:0], u};
        r.count = r.count + 3'd1;
      end
    end
  end

  // Drop the held letter on a register write, else advance codec state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid    <= 1'b0;
      held_letter   <= '0;
      error_latched <= 1'b0;
    end else if (cfg_clear) begin
      held_valid  <= 1'b0;
      held_letter <= '0;
    end else if (accept) begin
      held_valid    <= held_valid_next;
      held_letter   <= held_letter_next;
      error_latched <= error_latched_next;
    end
  end

  // Queue only items that give results
  assign push.push = accept && (r.count != '0);
  assign push.run  = r;

endmodule

// ===== rtl/core/pdtc_queue.sv =====
// Short run queue between the front and back end.
`timescale 1ns / 1ps

module pdtc_queue (
  input  logic            clk,
  input  logic            rst,
  input  pdtc_pkg::push_t push,
  output logic            q_full,
  input  logic            pop,
  output pdtc_pkg::head_t head
);
  import pdtc_pkg::*;

  run_t                 slots [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueueCntW-1:0] fill;
  logic                 do_push;
  logic                 do_pop;

  assign q_full  = (fill == QueueCntW'(QueueDepth));
  assign do_push = push.push && !q_full;
  assign do_pop  = pop && (fill != '0);

  assign head.valid = (fill != '0);
  assign head.run   = slots[rd_ptr];

  // Move pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Store the pushed run
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push.run;
  end

endmodule

// ===== rtl/core/pdtc_back.sv =====
// Back end: plays out each run one result item per cycle while out_stall is low.
`timescale 1ns / 1ps

module pdtc_back (
  input  logic            clk,
  input  logic            rst,
  input  pdtc_pkg::head_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            last_of_run,
  output logic            bad_char
);
  import pdtc_pkg::*;

  logic              busy;
  run_t              run;
  logic [CountW-1:0] idx;
  logic              done;

  assign out_valid   = busy;
  assign out_byte    = run.bytes[idx];
  assign last_of_run = (idx == '0);
  assign bad_char    = run.bad;

  // Current run is finished or nothing is loaded
  assign done = !busy || (!out_stall && idx == '0);
  assign pop  = done && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (done) begin
      busy <= head.valid;
    end
  end

  // Load the next run or step to its next byte
  always_ff @(posedge clk) begin
    if (pop) begin
      run <= head.run;
      idx <= head.run.count - 1'b1;
    end else if (busy && !out_stall && idx != '0) begin
      idx <= idx - 1'b1;
    end
  end

endmodule

// ===== rtl/core/punctuation_digraph_text_codec_unit.sv =====
// Top level of the punctuation digraph text codec.
`timescale 1ns / 1ps

// Usage:
// Input items (in_byte, end_of_text) enter on in_valid/in_stall; result items
// (out_byte, last_of_run, bad_char) leave on out_valid/out_stall. Each item
// gives zero to six results; last_of_run marks the final result of an item.
// The direction register (APB, address 0, bit 0) selects encode (0) or
// decode (1); writing it drops a held letter. Write it only while idle.
// An accepted item's run goes through the queue into the back end.
// Throughput: one item per cycle while each gives one result and out_stall
// is low; a longer run holds the output stage while the back end plays out
// one byte per cycle. A two-run queue lets the front end keep accepting
// while the back end is busy; in_stall rises only when that queue is full.
// When out_stall is high the current result holds and the queue fills.
// Reset clears the queue, the held letter, the sticky error and the
// direction (encode). A bad byte in encode latches an error; from then on
// every item gives one bad_char result until reset.

module punctuation_digraph_text_codec_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_byte,
  input  logic                          end_of_text,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_byte,
  output logic                          last_of_run,
  output logic                          bad_char,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pdtc_pkg::PaddrW-1:0]   paddr,
  input  logic [pdtc_pkg::PdataW-1:0]   pwdata,
  output logic [pdtc_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);
  import pdtc_pkg::*;

  dir_t  direction;
  logic  reg_hit;
  logic  cfg_clear;
  logic  q_full;
  logic  pop;
  push_t push;
  head_t head;

  // Register decode
  assign pready    = 1'b1;
  assign reg_hit   = (paddr[PaddrW-1:2] == RegDirection);
  assign cfg_clear = psel && penable && pwrite && reg_hit;
  assign prdata    = reg_hit ? {{(PdataW-1){1'b0}}, direction} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCODE;
    end else if (cfg_clear) begin
      direction <= dir_t'(pwdata[0]);
    end
  end

  pdtc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .direction   (direction),
    .cfg_clear   (cfg_clear),
    .q_full      (q_full),
    .push        (push)
  );

  pdtc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .q_full (q_full),
    .pop    (pop),
    .head   (head)
  );

  pdtc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .bad_char    (bad_char)
  );

  // An error result is always a run of one
  a_bad_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_char |-> last_of_run)
    else $error("bad_char result not marked last of its run");

  // A run does not break off before its last result
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_run |=> out_valid)
    else $error("result run ended early");

  // An accepted error result is not directly followed by a good result
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && bad_char |=> !(out_valid && !bad_char))
    else $error("good result after latched error");

endmodule

// ===== bench/punctuation_digraph_text_codec_unit_tb.sv =====
// Testbench: drives the digraph text codec and checks every result item against a predictor.
`timescale 1ns / 1ps

module punctuation_digraph_text_codec_unit_tb;
  import pdtc_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int HoldOffCycles = 300;
  localparam int SettleCycles = 4;
  localparam int RunItems = 35;
  localparam logic [PaddrW-1:0] DirectionAddr = {RegDirection, 2'b00};

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       bad;
  } result_t;

  // Predicts the result items of each accepted item and checks them in order
  class digraph_scoreboard;
    dir_t       direction;
    bit [7:0]   held;
    bit         held_ok;
    bit         err_latched;
    result_t    run[$];
    result_t    due[$];
    int         mismatches;

    function new();
      direction   = DIR_ENCODE;
      held        = 8'd0;
      held_ok     = 1'b0;
      err_latched = 1'b0;
      mismatches  = 0;
    endfunction

    function void set_direction(dir_t d);
      direction = d;
      held_ok   = 1'b0;
      held      = 8'd0;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void flag(string msg);
      if (mismatches < 10) $display("%s", msg);
      mismatches++;
    endfunction

    // Letters that stand for a symbol in encoded text; empty when none
    function string spelling_of(bit [7:0] b);
      case (b)
        "\\": return "LQ";
        ")":  return "QX";
        ":":  return "QZ";
        ",":  return "YY";
        "-":  return "YZ";
        "\"": return "XZ";
        "!":  return "ZY";
        "(":  return "XQ";
        "%":  return "PQ";
        ".":  return "ZZ";
        "#":  return "QP";
        ";":  return "ZQ";
        "'":  return "ZX";
        "/":  return "QL";
        " ":  return "XX";
        "?":  return "QQ";
        "1":  return "ONE";
        "2":  return "TWO";
        "3":  return "THREE";
        "4":  return "FOUR";
        "5":  return "FIVE";
        "6":  return "SIX";
        "7":  return "SEVEN";
        "8":  return "EIGT";
        "9":  return "NINE";
        "0":  return "ZERO";
        "&":  return "AND";
        "@":  return "AT";
        "=":  return "EQUALS";
        "+":  return "PLUS";
        "*":  return "STAR";
        default: return "";
      endcase
    endfunction

    // Invert the two-letter spellings; zero when the pair means nothing
    function bit [7:0] pair_symbol_of(bit [7:0] first, bit [7:0] second);
      string w;
      for (int s = 1; s < 128; s++) begin
        w = spelling_of(s[7:0]);
        if (w.len() == 2 && w[0] == first && w[1] == second) return s[7:0];
      end
      return 8'd0;
    endfunction

    // True when encode accepts the byte without raising an error
    function bit encodable(bit [7:0] b);
      if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) return 1'b1;
      if (b == CharNul || b == CharNewline) return 1'b1;
      if (b >= CharBraceL && b <= CharDel) return 1'b1;
      return spelling_of(b).len() != 0;
    endfunction

    function void emit(bit [7:0] c, bit bad);
      result_t r;
      r.ch   = c;
      r.last = 1'b0;
      r.bad  = bad;
      run.push_back(r);
    endfunction

    function void encode_byte(bit [7:0] b);
      string w;
      w = spelling_of(b);
      if (b >= "a" && b <= "z") emit(b - CaseOffset, 1'b0);
      else if (b >= "A" && b <= "Z") emit(b, 1'b0);
      else if (b == CharNul) return;
      else if (b == CharNewline) emit(b, 1'b0);
      else if (b >= CharBraceL && b <= CharDel) return;
      else if (w.len() == 0) begin
        err_latched = 1'b1;
        emit(b, 1'b1);
      end else begin
        for (int i = 0; i < w.len(); i++) emit(w[i], 1'b0);
      end
    endfunction

    function void decode_byte(bit [7:0] b, bit eot);
      bit [7:0] u;
      bit [7:0] sym;
      // NUL only flushes what is held
      if (b == CharNul) begin
        if (held_ok) emit(held, 1'b0);
        held_ok = 1'b0;
        held    = 8'd0;
        return;
      end
      u = (b >= "a" && b <= "z") ? b - CaseOffset : b;
      // Complete a pair against the raw byte, else release the held letter
      if (held_ok) begin
        sym = pair_symbol_of(held, b);
        held_ok = 1'b0;
        emit(sym != 8'd0 ? sym : held, 1'b0);
        held = 8'd0;
        if (sym != 8'd0) return;
      end
      if (u inside {"L", "P", "Q", "X", "Y", "Z"}) begin
        held    = u;
        held_ok = 1'b1;
      end else begin
        emit(u, 1'b0);
      end
      if (eot && held_ok) begin
        emit(held, 1'b0);
        held_ok = 1'b0;
        held    = 8'd0;
      end
    endfunction

    function void note_byte(bit [7:0] b, bit eot);
      run.delete();
      if (err_latched) emit(b, 1'b1);
      else if (direction == DIR_ENCODE) encode_byte(b);
      else decode_byte(b, eot);
      if (run.size() > 0) run[run.size()-1].last = 1'b1;
      foreach (run[i]) due.push_back(run[i]);
    endfunction

    function void check_char(logic [7:0] c, logic last, logic bad);
      result_t e;
      if (due.size() == 0) begin
        flag($sformatf("unexpected result: byte %02h last %b bad %b", c, last, bad));
        return;
      end
      e = due.pop_front();
      if (e.ch !== c || e.last !== last || e.bad !== bad)
        flag($sformatf("result mismatch: expected byte %02h last %b bad %b, got %02h %b %b",
                       e.ch, e.last, e.bad, c, last, bad));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_byte;
  logic              end_of_text;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_byte;
  logic              last_of_run;
  logic              bad_char;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  digraph_scoreboard sb = new();
  int  send_idle_pct;
  int  stall_pct;
  bit  hold_req;
  int  hold_left;
  int  quiet;

  punctuation_digraph_text_codec_unit dut (
    .clk, .rst, .in_valid, .in_stall, .in_byte, .end_of_text,
    .out_valid, .out_stall, .out_byte, .last_of_run, .bad_char,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk = ~clk;

  // Stall the output at random, or for a long stretch on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HoldOffCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Check each accepted result item
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_char(out_byte, last_of_run, bad_char);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet = 0;
    else quiet++;
    if (quiet >= QuietLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one item after a random gap and hold it until accepted
  task automatic offer_byte(input logic [7:0] b, input logic eot);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_byte     <= b;
    end_of_text <= eot;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b, eot);
  endtask

  task automatic feed_text(input string s, input bit eot_last);
    for (int i = 0; i < s.len(); i++) offer_byte(s[i], eot_last && (i == s.len() - 1));
  endtask

  // Hold input until every predicted result has come, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write the direction register, then read it back
  task automatic write_direction(input dir_t d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DirectionAddr;
    pwdata  <= PdataW'(d);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_direction(d);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[0] !== d)
      sb.flag($sformatf("direction readback: expected %0b, got %b", d, prdata[0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Well-formed pairs most often, then lone letters, noise, NUL or newline
  task automatic offer_decode_chunk(output int n);
    int       r;
    bit [7:0] s;
    bit [7:0] first;
    bit [7:0] second;
    string    w;
    r = $urandom_range(99);
    n = 1;
    if (r < 45) begin
      do begin
        s = 8'($urandom_range(32, 92));
        w = sb.spelling_of(s);
      end while (w.len() != 2 || s == "@");
      first  = ($urandom_range(9) == 0) ? w[0] + CaseOffset : w[0];
      second = ($urandom_range(9) == 0) ? w[1] + CaseOffset : w[1];
      offer_byte(first, $urandom_range(19) == 0);
      offer_byte(second, $urandom_range(19) == 0);
      n = 2;
    end else if (r < 75) begin
      s = 8'($urandom_range(65, 90));
      if ($urandom_range(1)) s = s + CaseOffset;
      offer_byte(s, $urandom_range(19) == 0);
    end else if (r < 88) begin
      offer_byte(8'($urandom_range(255)), $urandom_range(19) == 0);
    end else begin
      offer_byte($urandom_range(1) ? CharNul : CharNewline, $urandom_range(9) == 0);
    end
  endtask

  initial begin
    int       sent;
    int       n;
    int       errors;
    bit [7:0] b;
    dir_t     d;

    rst         <= 1'b1;
    in_valid    <= 1'b0;
    in_byte     <= 8'd0;
    end_of_text <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    hold_left     = 0;
    quiet         = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed encode: NUL, letter extremes, newline, long words, dropped bytes
    write_direction(DIR_ENCODE);
    offer_byte(CharNul, 1'b0);
    feed_text("azAZ\n", 1'b0);
    feed_text("=3,\\", 1'b1);
    offer_byte(CharBraceL, 1'b0);
    offer_byte(CharDel, 1'b0);
    drain_results();

    // Directed decode: pairs, lower-case second letter, NUL flush, end of text
    write_direction(DIR_DECODE);
    feed_text("LQ", 1'b0);
    feed_text("Qxq", 1'b0);
    offer_byte(CharNul, 1'b0);
    feed_text("Y", 1'b1);
    feed_text("XX", 1'b1);
    feed_text("PA", 1'b0);
    offer_byte(8'hFF, 1'b0);
    offer_byte(8'h80, 1'b0);
    drain_results();

    // Random runs in both directions under each idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < 2; k++) begin
        d = dir_t'(k);
        send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 68 : 10) : 0;
        stall_pct     = (ph == 2 || ph == 3) ? (ph == 2 ? 68 : 10) : 0;
        drain_results();
        write_direction(d);
        if (ph == 0 && k == 0) hold_req = 1'b1;
        sent = 0;
        while (sent < RunItems) begin
          if (d == DIR_ENCODE) begin
            do b = 8'($urandom_range(127)); while (!sb.encodable(b));
            offer_byte(b, $urandom_range(9) == 0);
            if (!(b == CharNul || (b >= CharBraceL && b <= CharDel))) sent++;
          end else begin
            offer_decode_chunk(n);
            sent += n;
          end
        end
      end
    end

    // Latch the sticky error, then keep going in both directions
    send_idle_pct = 10;
    stall_pct     = 10;
    drain_results();
    write_direction(DIR_ENCODE);
    feed_text("ok", 1'b0);
    do b = 8'($urandom_range(255)); while (sb.encodable(b));
    offer_byte(b, 1'b0);
    for (int i = 0; i < 15; i++) offer_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    drain_results();
    write_direction(DIR_DECODE);
    for (int i = 0; i < 15; i++) offer_byte(8'($urandom_range(255)), 1'($urandom_range(1)));

    drain_results();
    repeat (10) @(posedge clk);
    errors = sb.mismatches + sb.pending();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
